### hw/rtl/rcfp_pkg.sv
// Shared types, constants and the CRC-8 helper for the RC channel frame packer.
`default_nettype none

package rcfp_pkg;

	localparam int CHANNEL_COUNT = 16;
	localparam int CHAN_W        = 11;
	localparam int BYTE_W        = 8;
	localparam int CHAN_IDX_W    = $clog2(CHANNEL_COUNT);
	localparam int PAYLOAD_BYTES = (CHANNEL_COUNT * CHAN_W) / BYTE_W;
	localparam int CFG_INDEX_W   = 2;

	// leftover bits between requests never reach a full byte
	localparam int REM_W   = $clog2(BYTE_W);
	localparam int STORE_W = BYTE_W - 1;
	localparam int PACK_W  = STORE_W + CHAN_W;
	localparam int TOT_W   = $clog2(PACK_W + 1);

	localparam int CMDQ_DEPTH = 2;

	localparam logic [BYTE_W-1:0] LENGTH_BYTE = BYTE_W'(PAYLOAD_BYTES + 2);
	localparam logic [BYTE_W-1:0] ADDR_RESET  = 8'd200;
	localparam logic [BYTE_W-1:0] TYPE_RESET  = 8'd22;
	localparam logic [BYTE_W-1:0] CRC_POLY    = 8'hD5;

	typedef enum logic [CFG_INDEX_W-1:0] {
		REG_DEVICE_ADDRESS = 2'd0,
		REG_FRAME_TYPE     = 2'd1
	} cfg_reg_t;

	// one command per accepted channel: what the back end has to emit
	typedef struct packed {
		logic              first;
		logic              last;
		logic              two;
		logic [BYTE_W-1:0] addr;
		logic [BYTE_W-1:0] ftype;
		logic [BYTE_W-1:0] b0;
		logic [BYTE_W-1:0] b1;
	} cmd_t;

	typedef enum logic [2:0] {
		PH_HEAD,
		PH_ADDR,
		PH_LEN,
		PH_TYPE,
		PH_PAY0,
		PH_PAY1,
		PH_CRC
	} phase_t;

	// CRC-8 DVB-S2, MSB first
	function automatic logic [BYTE_W-1:0] crc8_update(input logic [BYTE_W-1:0] crc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] c;
		c = crc ^ data;
		for (int k = 0; k < BYTE_W; k++) begin
			c = c[BYTE_W-1] ? ((c << 1) ^ CRC_POLY) : (c << 1);
		end
		return c;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/rcfp_front.sv
// Front end: config registers, bit packing of channels into byte commands.
`default_nettype none

module rcfp_front (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 accept,
	input  wire  [rcfp_pkg::CHAN_W-1:0]         channel_value,
	input  wire                                 cfg_write,
	input  wire  [rcfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [rcfp_pkg::BYTE_W-1:0]         cfg_data,
	output rcfp_pkg::cmd_t                      cmd
);
	import rcfp_pkg::*;

	logic [BYTE_W-1:0]     addr_q;
	logic [BYTE_W-1:0]     ftype_q;
	logic [CHAN_IDX_W-1:0] idx_q;
	logic [REM_W-1:0]      rem_q;
	logic [STORE_W-1:0]    store_q;

	logic                  first;
	logic                  last_chan;
	logic [REM_W-1:0]      pend;
	logic [PACK_W-1:0]     packed_bits;
	logic [TOT_W-1:0]      total;
	logic                  two;
	logic [REM_W-1:0]      rem_next;
	logic [STORE_W-1:0]    store_next;

	always_comb begin
		first       = (idx_q == '0);
		last_chan   = (idx_q == CHAN_IDX_W'(CHANNEL_COUNT - 1));
		pend        = first ? '0 : rem_q;
		packed_bits = PACK_W'(first ? '0 : store_q) | (PACK_W'(channel_value) << pend);
		total       = TOT_W'(pend) + TOT_W'(CHAN_W);
		two         = (total >= TOT_W'(2 * BYTE_W));
		rem_next    = two ? REM_W'(total - TOT_W'(2 * BYTE_W)) : REM_W'(total - TOT_W'(BYTE_W));
		store_next  = two ? STORE_W'(packed_bits >> (2 * BYTE_W))
		                  : STORE_W'(packed_bits >> BYTE_W);
	end

	assign cmd.first = first;
	assign cmd.last  = last_chan;
	assign cmd.two   = two;
	assign cmd.addr  = addr_q;
	assign cmd.ftype = ftype_q;
	assign cmd.b0    = packed_bits[BYTE_W-1:0];
	assign cmd.b1    = packed_bits[2*BYTE_W-1:BYTE_W];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			addr_q  <= ADDR_RESET;
			ftype_q <= TYPE_RESET;
		end else if (cfg_write) begin
			unique case (cfg_reg_t'(cfg_index))
				REG_DEVICE_ADDRESS: addr_q  <= cfg_data;
				REG_FRAME_TYPE:     ftype_q <= cfg_data;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q   <= '0;
			rem_q   <= '0;
			store_q <= '0;
		end else if (accept) begin
			idx_q   <= idx_q + 1'b1;
			rem_q   <= last_chan ? '0 : rem_next;
			store_q <= last_chan ? '0 : store_next;
		end
	end

	// last channel must drain the accumulator exactly
	a_last_drains: assert property (@(posedge clk) disable iff (!arst_n)
		accept && last_chan |-> two && (rem_next == '0))
		else $error("bits left over at end of frame");

endmodule

`default_nettype wire

### hw/rtl/rcfp_cmd_fifo.sv
// Short command queue between front and back end.
`default_nettype none

module rcfp_cmd_fifo (
	input  wire             clk,
	input  wire             arst_n,
	input  wire             push,
	input  wire rcfp_pkg::cmd_t push_data,
	output logic            full,
	input  wire             pop,
	output logic            head_valid,
	output rcfp_pkg::cmd_t  head
);
	import rcfp_pkg::*;

	localparam int PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
	localparam int CNT_W = $clog2(CMDQ_DEPTH + 1);

	cmd_t             mem_q [CMDQ_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full       = (count_q == CNT_W'(CMDQ_DEPTH));
	assign head_valid = (count_q != '0);
	assign head       = mem_q[rd_ptr_q];
	assign do_push    = push && !full;
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(CMDQ_DEPTH))
		else $error("command queue count overflow");

	a_no_push_full: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full command queue");

endmodule

`default_nettype wire

### hw/rtl/rcfp_back.sv
// Back end: byte sequencer, running CRC and output register.
`default_nettype none

module rcfp_back (
	input  wire                          clk,
	input  wire                          arst_n,
	input  wire                          head_valid,
	input  wire rcfp_pkg::cmd_t          head,
	output logic                         head_pop,
	output logic                         empty,
	input  wire                          pop,
	output logic [rcfp_pkg::BYTE_W-1:0]  out_byte,
	output logic                         last_byte
);
	import rcfp_pkg::*;

	phase_t            phase_q;
	phase_t            eff_phase;
	phase_t            next_phase;
	logic              advance;
	logic [BYTE_W-1:0] crc_q;
	logic [BYTE_W-1:0] crc_d;
	logic [BYTE_W-1:0] byte_d;
	logic              last_d;
	logic              out_valid_q;
	logic [BYTE_W-1:0] out_byte_q;
	logic              out_last_q;

	assign advance   = head_valid && (!out_valid_q || pop);
	assign eff_phase = (phase_q == PH_HEAD) ? (head.first ? PH_ADDR : PH_PAY0) : phase_q;

	// next state
	always_comb begin
		next_phase = phase_q;
		if (advance) begin
			unique case (eff_phase)
				PH_ADDR: next_phase = PH_LEN;
				PH_LEN:  next_phase = PH_TYPE;
				PH_TYPE: next_phase = PH_PAY0;
				PH_PAY0: next_phase = head.two ? PH_PAY1 : (head.last ? PH_CRC : PH_HEAD);
				PH_PAY1: next_phase = head.last ? PH_CRC : PH_HEAD;
				PH_CRC:  next_phase = PH_HEAD;
				default: next_phase = PH_HEAD;
			endcase
		end
	end

	// outputs
	always_comb begin
		byte_d = '0;
		last_d = 1'b0;
		crc_d  = crc_q;
		unique case (eff_phase)
			PH_ADDR: byte_d = head.addr;
			PH_LEN:  byte_d = LENGTH_BYTE;
			PH_TYPE: begin
				byte_d = head.ftype;
				crc_d  = crc8_update('0, head.ftype);
			end
			PH_PAY0: begin
				byte_d = head.b0;
				crc_d  = crc8_update(crc_q, head.b0);
			end
			PH_PAY1: begin
				byte_d = head.b1;
				crc_d  = crc8_update(crc_q, head.b1);
			end
			PH_CRC: begin
				byte_d = crc_q;
				last_d = 1'b1;
			end
			default: ;
		endcase
	end

	assign head_pop  = advance && (next_phase == PH_HEAD);
	assign empty     = !out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = out_last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_HEAD;
			crc_q       <= '0;
			out_valid_q <= 1'b0;
			out_byte_q  <= '0;
			out_last_q  <= 1'b0;
		end else begin
			phase_q <= next_phase;
			if (advance) begin
				crc_q       <= crc_d;
				out_byte_q  <= byte_d;
				out_last_q  <= last_d;
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	a_crc_ends_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		advance && (eff_phase == PH_CRC) |=> phase_q == PH_HEAD)
		else $error("sequencer did not return to head after CRC");

	a_mid_cmd_held: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q != PH_HEAD) |-> head_valid)
		else $error("command left queue before it was finished");

endmodule

`default_nettype wire

### hw/rtl/rc_channel_frame_packer.sv
// Top level of the RC channel frame packer: front end, command queue, back end.
// A channel request passes through the command queue and the back end's output register to out_byte.
// The output gives one byte per cycle while pop is held and commands are queued; a request yields
// 1 or 2 payload bytes, 4 for channel 0, 3 for the last channel, as the back end sequences them.
// A two-entry command queue lets the front accept while the back end is still emitting.
// Reset (arst_n low, asynchronous): frame restarts at channel 0, queue and output empty,
// device_address = 200, frame_type = 22.
`default_nettype none

module rc_channel_frame_packer (
	input  wire                                 clk,
	input  wire                                 arst_n,
	// channel requests
	input  wire                                 push,
	output logic                                full,
	input  wire  [rcfp_pkg::CHAN_W-1:0]         channel_value,
	// frame bytes
	output logic                                empty,
	input  wire                                 pop,
	output logic [rcfp_pkg::BYTE_W-1:0]         out_byte,
	output logic                                last_byte,
	// register writes
	input  wire                                 cfg_valid,
	output logic                                cfg_ready,
	input  wire  [rcfp_pkg::CFG_INDEX_W-1:0]    cfg_index,
	input  wire  [rcfp_pkg::BYTE_W-1:0]         cfg_data
);
	import rcfp_pkg::*;

	cmd_t front_cmd;
	cmd_t head_cmd;
	logic accept;
	logic head_valid;
	logic head_pop;

	// register writes are always taken; address and type are latched into
	// the channel 0 command, so a write lands on the next frame
	assign cfg_ready = 1'b1;
	assign accept    = push && !full;

	rcfp_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.accept        (accept),
		.channel_value (channel_value),
		.cfg_write     (cfg_valid && cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.cmd           (front_cmd)
	);

	rcfp_cmd_fifo u_cmd_fifo (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (accept),
		.push_data  (front_cmd),
		.full       (full),
		.pop        (head_pop),
		.head_valid (head_valid),
		.head       (head_cmd)
	);

	rcfp_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head_cmd),
		.head_pop   (head_pop),
		.empty      (empty),
		.pop        (pop),
		.out_byte   (out_byte),
		.last_byte  (last_byte)
	);

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking bench for the RC channel frame packer: channel requests in, frame bytes checked.
`timescale 1ns / 1ps

module tb;
	import rcfp_pkg::*;

	// register indexes the block has no register behind; writes there must change nothing
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 2'd3;

	// length byte counts the payload plus type and CRC
	localparam logic [BYTE_W-1:0] FRAME_LEN = BYTE_W'((CHANNEL_COUNT * CHAN_W) / BYTE_W + 2);
	localparam logic [CHAN_W-1:0] CHAN_MAX  = '1;

	localparam int RANDOM_REQUESTS = 390;
	localparam int QUIET_REQUESTS  = 60;
	localparam int MAX_REPORTS     = 10;
	localparam int SETTLE_LIMIT    = 20000;

	// one whole frame of corner values: all-zero, all-one, single bits, alternating patterns
	localparam logic [CHAN_W-1:0] CORNER_CHANNELS [CHANNEL_COUNT] = '{
		11'd0,    11'd2047, 11'd1,    11'd1024,
		11'h555,  11'h2AA,  11'd2046, 11'd1023,
		11'd0,    11'd0,    11'd2047, 11'd2047,
		11'h0F0,  11'h70F,  11'd512,  11'd2047
	};

	typedef struct packed {
		logic [BYTE_W-1:0] value;
		logic              frame_end;
	} frame_byte_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	logic              push = 1'b0;
	logic [CHAN_W-1:0] channel_value = '0;
	logic              pop = 1'b0;
	logic              cfg_valid = 1'b0;
	logic [CFG_INDEX_W-1:0] cfg_index = '0;
	logic [BYTE_W-1:0] cfg_data = '0;

	logic              full;
	logic              empty;
	logic [BYTE_W-1:0] out_byte;
	logic              last_byte;
	logic              cfg_ready;

	rc_channel_frame_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.push          (push),
		.full          (full),
		.channel_value (channel_value),
		.empty         (empty),
		.pop           (pop),
		.out_byte      (out_byte),
		.last_byte     (last_byte),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// ---------------------------------------------------------------------------------
	// Frame predictor: own copy of the registers and of the packing state
	// ---------------------------------------------------------------------------------
	logic [BYTE_W-1:0]     reg_addr = ADDR_RESET;
	logic [BYTE_W-1:0]     reg_type = TYPE_RESET;
	logic [PACK_W-1:0]     pk_bits  = '0;	// bits not yet sent, LSB first
	logic [TOT_W-1:0]      pk_count = '0;	// how many of pk_bits are valid
	logic [CHAN_IDX_W-1:0] pk_chan  = '0;	// channel expected next
	logic [BYTE_W-1:0]     pk_crc   = '0;

	frame_byte_t frame_bytes_due [$];	// bytes still owed by the block, oldest first
	frame_byte_t due_byte;

	logic [CHAN_W-1:0] pending_channels [$];	// requests not yet taken by the block
	logic request_taken = 1'b0;

	int mismatches = 0;

	// idling controls, retuned per phase; quiet stops any new idle burst
	int  push_odds = 0;
	int  pop_odds  = 0;
	int  push_gap  = 0;
	int  pop_gap   = 0;
	logic quiet = 1'b0;

	// CRC-8 with poly 0xD5, shifted out MSB first
	function automatic logic [BYTE_W-1:0] crc8_next(input logic [BYTE_W-1:0] acc,
			input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0] r;
		r = acc ^ data;
		repeat (BYTE_W) r = {r[BYTE_W-2:0], 1'b0} ^ (r[BYTE_W-1] ? CRC_POLY : '0);
		return r;
	endfunction

	// works out the bytes one accepted channel request must produce
	task automatic pack_channel(input logic [CHAN_W-1:0] ch);
		if (pk_chan == '0) begin
			// header goes out with channel 0; address and type are taken here
			pk_bits  = '0;
			pk_count = '0;
			frame_bytes_due.push_back(frame_byte_t'{reg_addr, 1'b0});
			frame_bytes_due.push_back(frame_byte_t'{FRAME_LEN, 1'b0});
			frame_bytes_due.push_back(frame_byte_t'{reg_type, 1'b0});
			pk_crc = crc8_next('0, reg_type);
		end
		pk_bits  = pk_bits | (PACK_W'(ch) << pk_count[REM_W-1:0]);
		pk_count = TOT_W'(pk_count[REM_W-1:0]) + TOT_W'(CHAN_W);
		while (pk_count >= TOT_W'(BYTE_W)) begin
			frame_bytes_due.push_back(frame_byte_t'{pk_bits[BYTE_W-1:0], 1'b0});
			pk_crc   = crc8_next(pk_crc, pk_bits[BYTE_W-1:0]);
			pk_bits  = pk_bits >> BYTE_W;
			pk_count = pk_count - TOT_W'(BYTE_W);
		end
		if (pk_chan == CHAN_IDX_W'(CHANNEL_COUNT - 1)) begin
			// 176 payload bits divide evenly, so nothing is left over for the CRC
			frame_bytes_due.push_back(frame_byte_t'{pk_crc, 1'b1});
			pk_chan  = '0;
			pk_bits  = '0;
			pk_count = '0;
		end else begin
			pk_chan = pk_chan + 1'b1;
		end
	endtask

	task automatic report_fault(input string what);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t ns: %s", $time, what);
	endtask

	// ---------------------------------------------------------------------------------
	// Monitor: everything sampled on the rising edge
	// ---------------------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			request_taken <= push && !full;
			if (push && !full)
				pack_channel(channel_value);

			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_DEVICE_ADDRESS: reg_addr = cfg_data;
					REG_FRAME_TYPE:     reg_type = cfg_data;
					default: ;	// no register there
				endcase
			end

			if (pop && !empty) begin
				if (frame_bytes_due.size() == 0) begin
					report_fault($sformatf("unexpected byte %h last_byte %b", out_byte,
						last_byte));
				end else begin
					due_byte = frame_bytes_due.pop_front();
					if (out_byte !== due_byte.value || last_byte !== due_byte.frame_end)
						report_fault($sformatf("out_byte exp %h got %h, last_byte exp %b got %b",
							due_byte.value, out_byte, due_byte.frame_end, last_byte));
				end
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Request driver: offers the oldest pending channel, idles in bursts
	// ---------------------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (request_taken)
				void'(pending_channels.pop_front());
			if (push_gap > 0) begin
				push_gap--;
				push <= 1'b0;
			end else if (!quiet && push_odds != 0 && $urandom_range(push_odds - 1) == 0) begin
				// start a burst of idle cycles, this one included
				push_gap = $urandom_range(14);
				push <= 1'b0;
			end else if (pending_channels.size() != 0) begin
				push          <= 1'b1;
				channel_value <= pending_channels[0];
			end else begin
				push <= 1'b0;
			end
		end
	end

	// byte receiver: stalls in bursts the same way
	always @(negedge clk) begin
		if (arst_n) begin
			if (pop_gap > 0) begin
				pop_gap--;
				pop <= 1'b0;
			end else if (!quiet && pop_odds != 0 && $urandom_range(pop_odds - 1) == 0) begin
				pop_gap = $urandom_range(14);
				pop <= 1'b0;
			end else begin
				pop <= 1'b1;
			end
		end
	end

	// ---------------------------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------------------------
	function automatic logic [CHAN_W-1:0] pick_channel();
		case ($urandom_range(7))
			0:       return '0;
			1:       return CHAN_MAX;
			default: return CHAN_W'($urandom_range(CHAN_MAX));
		endcase
	endfunction

	function automatic logic [BYTE_W-1:0] pick_byte();
		case ($urandom_range(3))
			0:       return '0;
			1:       return '1;
			default: return BYTE_W'($urandom_range(255));
		endcase
	endfunction

	// 0 means no idling in this phase
	function automatic int pick_odds();
		case ($urandom_range(3))
			0:       return 0;
			1:       return 3;
			2:       return 8;
			default: return 24;
		endcase
	endfunction

	task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [BYTE_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// wait until every request is taken and every byte is out, then a few more cycles
	task automatic settle();
		int spin = 0;
		while ((pending_channels.size() != 0 || push || frame_bytes_due.size() != 0)
				&& spin < SETTLE_LIMIT) begin
			@(negedge clk);
			spin++;
		end
		repeat (8) @(negedge clk);
	endtask

	initial begin
		int left;
		int n;

		repeat (8) @(negedge clk);
		arst_n <= 1'b1;

		// a full frame of corner values on the reset defaults
		foreach (CORNER_CHANNELS[i])
			pending_channels.push_back(CORNER_CHANNELS[i]);
		settle();

		// spare indexes must be ignored; then the low extremes of address, high of type
		write_reg(REG_SPARE_A, 8'h00);
		write_reg(REG_SPARE_B, 8'hFF);
		write_reg(REG_DEVICE_ADDRESS, 8'h00);
		write_reg(REG_FRAME_TYPE, 8'hFF);

		// stop part way through a frame and retune: new values only show on the next frame
		pending_channels.push_back(CHAN_MAX);
		pending_channels.push_back('0);
		pending_channels.push_back(CHAN_MAX);
		pending_channels.push_back('0);
		pending_channels.push_back(11'd1);
		settle();
		write_reg(REG_DEVICE_ADDRESS, 8'hFF);
		write_reg(REG_FRAME_TYPE, 8'h00);

		// random phases; each ends wherever it lands in the frame
		left = RANDOM_REQUESTS;
		while (left > 0) begin
			push_odds = pick_odds();
			pop_odds  = pick_odds();
			n = $urandom_range(70, 10);
			if (n > left)
				n = left;
			repeat (n) pending_channels.push_back(pick_channel());
			left -= n;
			settle();
			if ($urandom_range(1))
				write_reg(REG_DEVICE_ADDRESS, pick_byte());
			if ($urandom_range(1))
				write_reg(REG_FRAME_TYPE, pick_byte());
			if ($urandom_range(7) == 0)
				write_reg($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B, pick_byte());
		end

		// closing stretch at full rate on both sides
		quiet = 1'b1;
		repeat (QUIET_REQUESTS) pending_channels.push_back(pick_channel());
		settle();

		if (frame_bytes_due.size() != 0)
			report_fault($sformatf("%0d bytes never arrived", frame_bytes_due.size()));

		if (mismatches == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	// watchdog, far beyond the slowest legal run
	initial begin
		#4ms;
		$display("tb failed");
		$finish;
	end

endmodule
